// File: design/assert_macros.svh
// assertion macros used by the deque top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define DEQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("deque check failed");

// condition that must never be seen
`define DEQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`DEQ_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// File: design/deq_pkg.sv
// types, constants and slot helpers of the double-ended queue
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int CMD_W = 3;
	localparam int COUNT_FIELD_W = 5;
	localparam int ERR_W = 2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [DATA_W-1:0] data_t;

	localparam idx_t IDX_LAST = idx_t'(DEPTH - 1);
	localparam cnt_t CNT_FULL = cnt_t'(DEPTH);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_REAR  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_REPORT     = 3'd4
	} cmd_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE  = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	// control bundle from pointer logic to the datapath
	typedef struct packed {
		logic wr_en;
		idx_t wr_addr;
		idx_t rd_front;
		idx_t rd_rear;
		cnt_t count;
		err_t err;
		logic fwd_front;
		logic fwd_rear;
	} deq_ctl_t;

	// ring step forward with wrap
	function automatic idx_t slot_next(idx_t s);
		return (s == IDX_LAST) ? '0 : idx_t'(s + idx_t'(1));
	endfunction

	// ring step backward with wrap
	function automatic idx_t slot_prev(idx_t s);
		return (s == '0) ? IDX_LAST : idx_t'(s - idx_t'(1));
	endfunction

	// count reported in the low bits of the result field
	function automatic logic [COUNT_FIELD_W-1:0] count_field(cnt_t c);
		logic [31:0] w;
		w = 32'(c);
		return w[COUNT_FIELD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: design/deq_ifs.sv
// request and result channel interfaces of the deque
`timescale 1ns / 1ps
`default_nettype none

interface deq_req_if;
	logic valid;
	logic ready;
	logic [deq_pkg::CMD_W-1:0] command;
	logic signed [deq_pkg::DATA_W-1:0] push_value;

	modport source (output valid, output command, output push_value, input ready);
	modport sink (input valid, input command, input push_value, output ready);
endinterface

interface deq_rsp_if;
	logic valid;
	logic ready;
	logic signed [deq_pkg::DATA_W-1:0] front_value;
	logic signed [deq_pkg::DATA_W-1:0] rear_value;
	logic [deq_pkg::COUNT_FIELD_W-1:0] item_count;
	logic is_empty;
	logic is_full;
	logic [deq_pkg::ERR_W-1:0] error_code;

	modport source (output valid, output front_value, output rear_value,
		output item_count, output is_empty, output is_full, output error_code,
		input ready);
	modport sink (input valid, input front_value, input rear_value,
		input item_count, input is_empty, input is_full, input error_code,
		output ready);
endinterface

`default_nettype wire

// File: design/deq_mem.sv
// item store: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module deq_mem (
	input  wire logic           clk,
	input  wire logic           wr_en,
	input  wire deq_pkg::idx_t  wr_addr,
	input  wire deq_pkg::data_t wr_data,
	input  wire logic           rd_en,
	input  wire deq_pkg::idx_t  rd_addr_a,
	input  wire deq_pkg::idx_t  rd_addr_b,
	output deq_pkg::data_t      rd_data_a,
	output deq_pkg::data_t      rd_data_b
);

	deq_pkg::data_t mem_q [deq_pkg::DEPTH];
	deq_pkg::data_t rd_data_a_q;
	deq_pkg::data_t rd_data_b_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read ports, old data on a same-cycle write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a_q <= mem_q[rd_addr_a];
			rd_data_b_q <= mem_q[rd_addr_b];
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

`default_nettype wire

// File: design/deq_ctrl.sv
// head, tail and count registers with command decode
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic [deq_pkg::CMD_W-1:0]  command,
	output deq_pkg::deq_ctl_t               ctl
);

	deq_pkg::idx_t head_q;
	deq_pkg::idx_t tail_q;
	deq_pkg::cnt_t count_q;
	deq_pkg::idx_t head_n;
	deq_pkg::idx_t tail_n;
	deq_pkg::cnt_t count_n;
	logic          is_full;
	logic          is_empty;

	assign is_full  = (count_q == deq_pkg::CNT_FULL);
	assign is_empty = (count_q == '0);

	// next pointers, store write and read addresses
	always_comb begin
		head_n        = head_q;
		tail_n        = tail_q;
		count_n       = count_q;
		ctl.wr_en     = 1'b0;
		ctl.wr_addr   = tail_q;
		ctl.err       = deq_pkg::ERR_NONE;
		case (command)
			deq_pkg::CMD_PUSH_FRONT: begin
				if (is_full) begin
					ctl.err = deq_pkg::ERR_FULL;
				end else begin
					head_n      = deq_pkg::slot_prev(head_q);
					ctl.wr_en   = 1'b1;
					ctl.wr_addr = head_n;
					count_n     = deq_pkg::cnt_t'(count_q + deq_pkg::cnt_t'(1));
				end
			end
			deq_pkg::CMD_PUSH_REAR: begin
				if (is_full) begin
					ctl.err = deq_pkg::ERR_FULL;
				end else begin
					ctl.wr_en   = 1'b1;
					ctl.wr_addr = tail_q;
					tail_n      = deq_pkg::slot_next(tail_q);
					count_n     = deq_pkg::cnt_t'(count_q + deq_pkg::cnt_t'(1));
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (is_empty) begin
					ctl.err = deq_pkg::ERR_EMPTY;
				end else begin
					head_n  = deq_pkg::slot_next(head_q);
					count_n = deq_pkg::cnt_t'(count_q - deq_pkg::cnt_t'(1));
				end
			end
			deq_pkg::CMD_POP_REAR: begin
				if (is_empty) begin
					ctl.err = deq_pkg::ERR_EMPTY;
				end else begin
					tail_n  = deq_pkg::slot_prev(tail_q);
					count_n = deq_pkg::cnt_t'(count_q - deq_pkg::cnt_t'(1));
				end
			end
			default: begin
				// report only, unused codes act the same
			end
		endcase
		ctl.wr_en     = ctl.wr_en & accept;
		ctl.rd_front  = head_n;
		ctl.rd_rear   = deq_pkg::slot_prev(tail_n);
		ctl.count     = count_n;
		// the read sees old data where it hits the slot being written
		ctl.fwd_front = ctl.wr_en && (ctl.rd_front == ctl.wr_addr);
		ctl.fwd_rear  = ctl.wr_en && (ctl.rd_rear == ctl.wr_addr);
	end

	// pointer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			count_q <= count_n;
		end
	end

endmodule

`default_nettype wire

// File: design/double_ended_queue_core.sv
// top level of the double-ended queue: pointer control, store and result stage
//
//   channel | modport | carries
//   --------+---------+-------------------------------------------------
//   req     | sink    | command, push_value
//   rsp     | source  | front_value, rear_value, item_count, is_empty,
//           |         | is_full, error_code
//
// one request per cycle while req.ready is high; results go from the read stage
// to the output register. Pointers and write settle at acceptance; the store
// registers front and rear read data, which then enter the output register
// a stalled result holds the read stage, and req.ready falls only when both are full
// reset clears pointers, count and valid flags; store contents are left as they are
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module double_ended_queue_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	deq_req_if.sink    req,
	deq_rsp_if.source  rsp
);

	logic              accept;
	logic              advance_s1;
	deq_pkg::deq_ctl_t ctl;
	deq_pkg::data_t    rd_front;
	deq_pkg::data_t    rd_rear;

	logic              valid_s1;
	deq_pkg::cnt_t     count_s1;
	deq_pkg::err_t     err_s1;
	logic              fwd_front_s1;
	logic              fwd_rear_s1;
	deq_pkg::data_t    value_s1;

	logic              out_valid_q;
	deq_pkg::data_t    front_q;
	deq_pkg::data_t    rear_q;
	deq_pkg::cnt_t     count_q;
	deq_pkg::err_t     err_q;

	// handshake
	assign advance_s1 = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready  = !valid_s1 || advance_s1;
	assign accept     = req.valid && req.ready;

	deq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.command (req.command),
		.ctl     (ctl)
	);

	deq_mem u_mem (
		.clk       (clk),
		.wr_en     (ctl.wr_en),
		.wr_addr   (ctl.wr_addr),
		.wr_data   (deq_pkg::data_t'(req.push_value)),
		.rd_en     (accept),
		.rd_addr_a (ctl.rd_front),
		.rd_addr_b (ctl.rd_rear),
		.rd_data_a (rd_front),
		.rd_data_b (rd_rear)
	);

	// read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= accept;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			count_s1     <= ctl.count;
			err_s1       <= ctl.err;
			fwd_front_s1 <= ctl.fwd_front;
			fwd_rear_s1  <= ctl.fwd_rear;
			value_s1     <= deq_pkg::data_t'(req.push_value);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || rsp.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	// output register payload, zero values when empty
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			count_q <= count_s1;
			err_q   <= err_s1;
			if (count_s1 == '0) begin
				front_q <= '0;
				rear_q  <= '0;
			end else begin
				front_q <= fwd_front_s1 ? value_s1 : rd_front;
				rear_q  <= fwd_rear_s1 ? value_s1 : rd_rear;
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.front_value = signed'(front_q);
	assign rsp.rear_value  = signed'(rear_q);
	assign rsp.item_count  = deq_pkg::count_field(count_q);
	assign rsp.is_empty    = (count_q == '0);
	assign rsp.is_full     = (count_q == deq_pkg::CNT_FULL);
	assign rsp.error_code  = err_q;

	// checks
	`DEQ_ASSERT_NEVER(a_count_range, clk, arst_n, valid_s1 && (count_s1 > deq_pkg::CNT_FULL))
	`DEQ_ASSERT(a_full_err, clk, arst_n, (valid_s1 && err_s1 == deq_pkg::ERR_FULL) |-> (count_s1 == deq_pkg::CNT_FULL))
	`DEQ_ASSERT(a_empty_err, clk, arst_n, (valid_s1 && err_s1 == deq_pkg::ERR_EMPTY) |-> (count_s1 == '0))
	`DEQ_ASSERT(a_hold_s1, clk, arst_n, (valid_s1 && !advance_s1) |=> (valid_s1 && $stable(count_s1)))

endmodule

`default_nettype wire

// File: tb/sv/deq_result_checker.sv
// result checker of the deque: mirrors the ring, predicts every result and compares it
`timescale 1ns / 1ps

module deq_result_checker
	import deq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	deq_req_if   req,
	deq_rsp_if   rsp,
	output int   pending,
	output int   mismatches,
	output int   results_seen,
	output int   empty_pops,
	output int   full_pushes
);

	// one predicted result, fields at the channel widths
	typedef struct packed {
		data_t                    front;
		data_t                    rear;
		logic [COUNT_FIELD_W-1:0] count;
		logic                     empty;
		logic                     full;
		err_t                     err;
	} deq_status_t;

	// mirror of the ring: slot of the front item, slot past the rear item, item count
	data_t ring [DEPTH];
	int front_slot = 0;
	int rear_next = 0;
	int held = 0;

	deq_status_t status_q [$];
	int errs = 0;
	int checked = 0;
	int n_empty = 0;
	int n_full = 0;

	// apply one request to the mirror and return the status it reports
	function automatic deq_status_t apply_request(input logic [CMD_W-1:0] code,
		input data_t value);
		deq_status_t s;
		s.err = ERR_NONE;
		case (code)
			CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
				if (held == DEPTH) begin
					s.err = ERR_FULL;
					n_full++;
				end else if (code == CMD_PUSH_FRONT) begin
					front_slot = (front_slot + DEPTH - 1) % DEPTH;
					ring[idx_t'(front_slot)] = value;
					held++;
				end else begin
					ring[idx_t'(rear_next)] = value;
					rear_next = (rear_next + 1) % DEPTH;
					held++;
				end
			end
			CMD_POP_FRONT, CMD_POP_REAR: begin
				if (held == 0) begin
					s.err = ERR_EMPTY;
					n_empty++;
				end else if (code == CMD_POP_FRONT) begin
					front_slot = (front_slot + 1) % DEPTH;
					held--;
				end else begin
					rear_next = (rear_next + DEPTH - 1) % DEPTH;
					held--;
				end
			end
			// report and the unused codes leave the ring alone
			default: ;
		endcase
		s.front = (held != 0) ? ring[idx_t'(front_slot)] : '0;
		s.rear = (held != 0) ? ring[idx_t'((rear_next + DEPTH - 1) % DEPTH)] : '0;
		s.count = COUNT_FIELD_W'(held);
		s.empty = (held == 0);
		s.full = (held == DEPTH);
		return s;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errs++;
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
		end
	endtask

	// compare results against the oldest prediction, then queue the new request
	always @(posedge clk or negedge arst_n) begin : watch
		deq_status_t want;
		if (!arst_n) begin
			front_slot = 0;
			rear_next = 0;
			held = 0;
			status_q.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (status_q.size() == 0) begin
					errs++;
					$display("%0t ns: result with no request waiting, expected none, got %h %h",
						$time, rsp.front_value, rsp.rear_value);
				end else begin
					want = status_q.pop_front();
					checked++;
					check_field("front_value", want.front, rsp.front_value);
					check_field("rear_value", want.rear, rsp.rear_value);
					check_field("item_count", 32'(want.count), 32'(rsp.item_count));
					check_field("is_empty", 32'(want.empty), 32'(rsp.is_empty));
					check_field("is_full", 32'(want.full), 32'(rsp.is_full));
					check_field("error_code", 32'(want.err), 32'(rsp.error_code));
				end
			end
			if (req.valid && req.ready)
				status_q.push_back(apply_request(req.command, req.push_value));
		end
		pending <= status_q.size();
		mismatches <= errs;
		results_seen <= checked;
		empty_pops <= n_empty;
		full_pushes <= n_full;
	end

endmodule

// File: tb/sv/tb_top.sv
// top of the deque testbench: clock, reset, request and result traffic, verdict
`timescale 1ns / 1ps

module tb_top;
	import deq_pkg::*;

	localparam int RANDOM_ITEMS = 450;
	localparam int QUIET_LIMIT = 1000;
	localparam int TAIL_CYCLES = 8;
	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST = 3'd7;

	logic clk;
	logic arst_n;
	bit steady = 1'b0;
	int sent = 0;
	int quiet_cycles = 0;
	int pending, mismatches, results_seen, empty_pops, full_pushes;

	deq_req_if req_ch ();
	deq_rsp_if rsp_ch ();

	double_ended_queue_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deq_result_checker result_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req_ch),
		.rsp          (rsp_ch),
		.pending      (pending),
		.mismatches   (mismatches),
		.results_seen (results_seen),
		.empty_pops   (empty_pops),
		.full_pushes  (full_pushes)
	);

	// 125 MHz clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// idle length: mostly none or short, a few long, none in steady stretches
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// push data with the extremes showing up often
	function automatic data_t pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	// present one request and hold it until accepted
	task automatic send(input logic [CMD_W-1:0] code, input data_t value);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.command <= code;
		req_ch.push_value <= value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
		gap = idle_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// result side: bursts of ready broken by stalls
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			stall = idle_gap();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// request stimulus and verdict
	initial begin
		int directed_count, random_sent, kind, len, i, v, push_pct;
		logic [CMD_W-1:0] code;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_REPORT;
		req_ch.push_value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme values, every command, pops on empty, unused codes
		send(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
		send(CMD_PUSH_REAR, 32'h8000_0000);
		send(CMD_REPORT, pick_value());
		for (v = int'(CMD_UNUSED_FIRST); v <= int'(CMD_UNUSED_LAST); v++)
			send(CMD_W'(v), pick_value());
		send(CMD_POP_FRONT, pick_value());
		send(CMD_POP_REAR, pick_value());
		send(CMD_POP_FRONT, pick_value());
		send(CMD_POP_REAR, pick_value());
		send(CMD_REPORT, 32'hFFFF_FFFF);
		send(CMD_PUSH_REAR, 32'h0000_0000);
		send(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
		send(CMD_POP_REAR, pick_value());
		send(CMD_POP_FRONT, pick_value());
		directed_count = sent;

		// random phases biased toward filling, draining or churning; first one fills
		random_sent = 0;
		kind = 0;
		while (random_sent < RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 5) == 0);
			len = $urandom_range(15, 40);
			push_pct = (kind == 0) ? 85 : (kind == 1) ? 15 : 50;
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 99) < 5)
					code = CMD_W'($urandom_range(CMD_REPORT, CMD_UNUSED_LAST));
				else if ($urandom_range(0, 99) < push_pct)
					code = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
				else
					code = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
				send(code, pick_value());
			end
			random_sent += len;
			kind = $urandom_range(0, 2);
		end
		steady = 1'b0;
		req_ch.valid <= 1'b0;

		// drain outstanding results, then keep watching for stray results
		do
			@(posedge clk);
		while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run summary: %0d requests (%0d directed), %0d results compared",
			sent, directed_count, results_seen);
		$display("run summary: %0d pops on an empty deque, %0d pushes on a full deque",
			empty_pops, full_pushes);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
